FILE: rtl/dcr_pkg.sv
// Shared types and constants for the debounced change reporter.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package dcr_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_HEARTBEAT_TICKS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STABLE_TICKS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FAIL_LIMIT      = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] HEARTBEAT_TICKS_RST = 8'd30;
    localparam logic [5:0] STABLE_TICKS_RST    = 6'd3;
    localparam logic [3:0] FAIL_LIMIT_RST      = 4'd3;

    // Saturation limits of the counters
    localparam logic [7:0] HEARTBEAT_MAX = 8'hFF;
    localparam logic [5:0] STABLE_MAX    = 6'h3F;
    localparam logic [3:0] FAIL_MAX      = 4'hF;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_HEARTBEAT = 2'd1,
        ACT_CHANGE    = 2'd2,
        ACT_REINIT    = 2'd3
    } action_t;

    // Operation codes of an input item
    localparam logic OP_POLL    = 1'b0;
    localparam logic OP_OUTCOME = 1'b1;

    typedef struct packed {
        logic operation;
        logic low_switch;
        logic half_switch;
        logic full_switch;
        logic tx_ok;
    } in_item_t;

    typedef struct packed {
        action_t action;
        logic    send_low;
        logic    send_half;
        logic    send_full;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/dcr_in_stage.sv
// Input register of the debounced change reporter.
// Depends on dcr_pkg for the input item type.
`default_nettype none

module dcr_in_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire dcr_pkg::in_item_t s_item,
    input  wire logic             advance,
    output logic                  item_valid,
    output dcr_pkg::in_item_t     item
);

    logic              valid_reg;
    logic              valid_next;
    dcr_pkg::in_item_t item_reg;

    // Free slot, or the held item moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: rtl/dcr_core.sv
// Decision logic and state of the debounced change reporter: debounce,
// heartbeat timer, failure counter and configuration registers. Uses dcr_pkg.
`default_nettype none

module dcr_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [dcr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [dcr_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  wire logic                                 advance,
    input  wire dcr_pkg::in_item_t                    item,
    output dcr_pkg::out_item_t                        result
);

    // Configuration
    logic [7:0] heartbeat_ticks_reg;
    logic [5:0] stable_ticks_reg;
    logic [3:0] fail_limit_reg;

    // Block state
    logic [2:0] sent_bits_reg,      sent_bits_next;
    logic       sent_valid_reg,     sent_valid_next;
    logic [2:0] cand_bits_reg,      cand_bits_next;
    logic       cand_active_reg,    cand_active_next;
    logic [5:0] stable_count_reg,   stable_count_next;
    logic [7:0] hb_count_reg,       hb_count_next;
    logic [3:0] fail_count_reg,     fail_count_next;
    logic [2:0] pending_bits_reg,   pending_bits_next;
    logic       startup_due_reg,    startup_due_next;

    logic [2:0] cur;
    logic       changed;
    logic       new_cand;
    logic [5:0] stable_eff;
    logic [7:0] hb_inc;
    logic [3:0] fail_inc;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heartbeat_ticks_reg <= dcr_pkg::HEARTBEAT_TICKS_RST;
            stable_ticks_reg    <= dcr_pkg::STABLE_TICKS_RST;
            fail_limit_reg      <= dcr_pkg::FAIL_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dcr_pkg::REG_HEARTBEAT_TICKS: heartbeat_ticks_reg <= cfg_wdata[7:0];
                dcr_pkg::REG_STABLE_TICKS:    stable_ticks_reg    <= cfg_wdata[5:0];
                dcr_pkg::REG_FAIL_LIMIT:      fail_limit_reg      <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Sample packing: low in bit 0, full in bit 2
    assign cur        = {item.full_switch, item.half_switch, item.low_switch};
    assign changed    = !sent_valid_reg || (cur != sent_bits_reg);
    assign new_cand   = !cand_active_reg || (cur != cand_bits_reg);
    assign stable_eff = new_cand ? 6'd0 : stable_count_reg;
    assign hb_inc     = (hb_count_reg == dcr_pkg::HEARTBEAT_MAX) ? hb_count_reg
                                                                  : hb_count_reg + 8'd1;
    assign fail_inc   = (fail_count_reg == dcr_pkg::FAIL_MAX) ? fail_count_reg
                                                               : fail_count_reg + 4'd1;

    // Next state and result for the item in the input register
    always_comb begin
        sent_bits_next    = sent_bits_reg;
        sent_valid_next   = sent_valid_reg;
        cand_bits_next    = cand_bits_reg;
        cand_active_next  = cand_active_reg;
        stable_count_next = stable_count_reg;
        hb_count_next     = hb_count_reg;
        fail_count_next   = fail_count_reg;
        pending_bits_next = pending_bits_reg;
        startup_due_next  = startup_due_reg;
        result            = '{action: dcr_pkg::ACT_NONE, default: 1'b0};

        if (item.operation == dcr_pkg::OP_OUTCOME) begin
            if (item.tx_ok) begin
                fail_count_next = 4'd0;
                sent_bits_next  = pending_bits_reg;
                sent_valid_next = 1'b1;
            end else if (fail_inc >= fail_limit_reg) begin
                fail_count_next = 4'd0;
                result.action   = dcr_pkg::ACT_REINIT;
            end else begin
                fail_count_next = fail_inc;
            end
        end else if (startup_due_reg) begin
            // First poll after reset: heartbeat only
            startup_due_next  = 1'b0;
            hb_count_next     = 8'd0;
            cand_active_next  = 1'b0;
            pending_bits_next = cur;
            result            = '{dcr_pkg::ACT_HEARTBEAT, cur[0], cur[1], cur[2]};
        end else if (changed && (stable_eff >= stable_ticks_reg)) begin
            // Candidate has held long enough
            cand_bits_next    = cur;
            cand_active_next  = 1'b0;
            stable_count_next = stable_eff;
            hb_count_next     = 8'd0;
            pending_bits_next = cur;
            result            = '{dcr_pkg::ACT_CHANGE, cur[0], cur[1], cur[2]};
        end else begin
            if (changed) begin
                cand_bits_next    = cur;
                cand_active_next  = 1'b1;
                stable_count_next = (stable_eff == dcr_pkg::STABLE_MAX) ? stable_eff
                                                                       : stable_eff + 6'd1;
            end else begin
                cand_active_next  = 1'b0;
            end
            // Heartbeat timer
            if (hb_inc >= heartbeat_ticks_reg) begin
                hb_count_next     = 8'd0;
                cand_active_next  = 1'b0;
                pending_bits_next = cur;
                result            = '{dcr_pkg::ACT_HEARTBEAT, cur[0], cur[1], cur[2]};
            end else begin
                hb_count_next     = hb_inc;
            end
        end
    end

    // State update when the item moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_bits_reg    <= 3'd0;
            sent_valid_reg   <= 1'b0;
            cand_bits_reg    <= 3'd0;
            cand_active_reg  <= 1'b0;
            stable_count_reg <= 6'd0;
            hb_count_reg     <= 8'd0;
            fail_count_reg   <= 4'd0;
            pending_bits_reg <= 3'd0;
            startup_due_reg  <= 1'b1;
        end else if (advance) begin
            sent_bits_reg    <= sent_bits_next;
            sent_valid_reg   <= sent_valid_next;
            cand_bits_reg    <= cand_bits_next;
            cand_active_reg  <= cand_active_next;
            stable_count_reg <= stable_count_next;
            hb_count_reg     <= hb_count_next;
            fail_count_reg   <= fail_count_next;
            pending_bits_reg <= pending_bits_next;
            startup_due_reg  <= startup_due_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dcr_out_stage.sv
// Result register of the debounced change reporter; produces the advance
// strobe for the stages before it. Uses dcr_pkg for the result item type.
`default_nettype none

module dcr_out_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               item_valid,
    input  wire dcr_pkg::out_item_t result,
    output logic                    advance,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output dcr_pkg::out_item_t      m_item
);

    logic               valid_reg;
    logic               valid_next;
    dcr_pkg::out_item_t item_reg;

    // Result register is free or drains this cycle
    assign advance = item_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

`default_nettype wire

FILE: rtl/debounced_change_reporter.sv
// Top level of the debounced change reporter: input register, decision core,
// result register. Depends on dcr_pkg, dcr_in_stage, dcr_core, dcr_out_stage.
//
// The block takes one item per clock unless stalled. An item is either a poll tick
// or a transmit outcome, and each item yields exactly one result item. The result
// shows on m_valid once the item moves into the result register. While the item
// sits in the input register, the core decides and updates its state. The result
// register then holds the outcome until it is taken. While m_ready stays high the
// block takes an item every cycle. Once both registers are full and m_ready is
// low, s_ready drops. The only stages are the input and result registers. The
// user must write configuration registers through cfg_wr_en/cfg_index/cfg_wdata
// only while no item is in flight; the block itself does not enforce this.
`default_nettype none

module debounced_change_reporter (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dcr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dcr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire dcr_pkg::in_item_t               s_item,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output dcr_pkg::out_item_t                   m_item
);

    logic               advance;
    logic               item_valid;
    dcr_pkg::in_item_t  item;
    dcr_pkg::out_item_t result;

    dcr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dcr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    dcr_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

`default_nettype wire

FILE: rtl/dcr_checker.sv
// Port-level checks for the debounced change reporter, bound to the top level.
// Depends on dcr_pkg and debounced_change_reporter.
`default_nettype none

module dcr_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire dcr_pkg::out_item_t m_item
);

    // Out of reset the block is empty and ready for an item
    a_reset_empty: assert property (@(posedge aclk)
        (aresetn && !$past(aresetn)) |-> (s_ready && !m_valid))
        else $error("block not empty after reset");

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result withdrawn before accepted");

    // A stalled result holds its payload
    a_item_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_item))
        else $error("result changed while stalled");

    // Switch values travel only with a send
    a_quiet_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_item.action == dcr_pkg::ACT_NONE
                     || m_item.action == dcr_pkg::ACT_REINIT))
        |-> (!m_item.send_low && !m_item.send_half && !m_item.send_full))
        else $error("switch bits set on a result without a send");

endmodule

bind debounced_change_reporter dcr_checker u_dcr_checker (.*);

`default_nettype wire
